>>> rtl/segi_pkg.sv
// segi_pkg: widths, pipeline depths and the stage-to-stage types of the segment intersection block
// no dependencies; every other file of the block imports it
package segi_pkg;

    localparam int COORD_W      = 16;
    localparam int WORD_W       = 64;
    localparam int DIFF_W       = COORD_W + 1;
    localparam int PROD_W       = 2 * COORD_W + 2;
    localparam int DEN_EXACT_W  = 2 * COORD_W + 3;
    localparam int NUM_EXACT_W  = 3 * COORD_W + 5;
    // intermediates wrap modulo 2^64 once they outgrow the 64-bit word
    localparam int DEN_W        = (DEN_EXACT_W < WORD_W) ? DEN_EXACT_W : WORD_W;
    localparam int NUM_W        = (NUM_EXACT_W < WORD_W) ? NUM_EXACT_W : WORD_W;
    // without wrap the point lies on segment a, so the quotient fits COORD_W magnitude bits
    localparam int QUO_W        = (NUM_EXACT_W <= WORD_W) ? COORD_W : WORD_W;

    localparam int FRONT_STAGES = 6;
    localparam int DIV_STAGES   = QUO_W;
    localparam int PIPE_STAGES  = FRONT_STAGES + DIV_STAGES;
    localparam int SKID_DEPTH   = 2;
    localparam int SKID_CNT_W   = $clog2(SKID_DEPTH + 1);

    typedef logic signed [COORD_W-1:0] coord_t;

    // front end to divider: magnitudes and sign of each quotient
    typedef struct packed {
        logic             hit;
        logic             neg_x;
        logic             neg_y;
        logic [NUM_W-1:0] mag_x;
        logic [NUM_W-1:0] mag_y;
        logic [DEN_W-1:0] mag_d;
    } segi_div_req_t;

    // divider to output stage
    typedef struct packed {
        logic             hit;
        logic             neg_x;
        logic             neg_y;
        logic [QUO_W-1:0] quo_x;
        logic [QUO_W-1:0] quo_y;
    } segi_div_rsp_t;

endpackage

>>> rtl/segi_in_if.sv
// segi_in_if: input channel carrying the end points of both segments
// depends on segi_pkg
interface segi_in_if import segi_pkg::*; ();

    logic   valid;
    logic   ready;
    coord_t a_start_x;
    coord_t a_start_y;
    coord_t a_end_x;
    coord_t a_end_y;
    coord_t b_start_x;
    coord_t b_start_y;
    coord_t b_end_x;
    coord_t b_end_y;

    modport source (
        output valid,
        output a_start_x, a_start_y, a_end_x, a_end_y,
        output b_start_x, b_start_y, b_end_x, b_end_y,
        input  ready
    );

    modport sink (
        input  valid,
        input  a_start_x, a_start_y, a_end_x, a_end_y,
        input  b_start_x, b_start_y, b_end_x, b_end_y,
        output ready
    );

endinterface

>>> rtl/segi_out_if.sv
// segi_out_if: result channel carrying the hit flag and the intersection point
// depends on segi_pkg
interface segi_out_if import segi_pkg::*; ();

    logic   valid;
    logic   ready;
    logic   hit;
    coord_t cross_x;
    coord_t cross_y;

    modport source (
        output valid,
        output hit, cross_x, cross_y,
        input  ready
    );

    modport sink (
        input  valid,
        input  hit, cross_x, cross_y,
        output ready
    );

endinterface

>>> rtl/segi_front.sv
// segi_front: six-stage front end: differences, cross products, hit test,
// point numerators and quotient magnitudes; depends on segi_pkg
module segi_front import segi_pkg::*; (
    input  logic          clk,
    input  logic          en,
    input  coord_t        a_start_x,
    input  coord_t        a_start_y,
    input  coord_t        a_end_x,
    input  coord_t        a_end_y,
    input  coord_t        b_start_x,
    input  coord_t        b_start_y,
    input  coord_t        b_end_x,
    input  coord_t        b_end_y,
    output segi_div_req_t req
);

    // true when num/den lies in [0,1] for nonzero den; the caller tests den for zero
    function automatic logic in_unit(input logic signed [DEN_W-1:0] num,
                                     input logic signed [DEN_W-1:0] den);
        logic res;
        if (!den[DEN_W-1])
        begin
            res = !num[DEN_W-1] && (num <= den);
        end
        else
        begin
            res = (num[DEN_W-1] || (num == '0)) && (num >= den);
        end
        return res;
    endfunction

    // stage 1: differences
    logic signed [DIFF_W-1:0] dxa_next, dya_next, dxb_next, dyb_next, dx13_next, dy13_next;
    logic signed [DIFF_W-1:0] dxa_s1_reg, dya_s1_reg, dxb_reg, dyb_reg, dx13_reg, dy13_reg;
    coord_t                   x1_s1_reg, y1_s1_reg;

    assign dxa_next  = DIFF_W'(a_end_x)   - DIFF_W'(a_start_x);
    assign dya_next  = DIFF_W'(a_end_y)   - DIFF_W'(a_start_y);
    assign dxb_next  = DIFF_W'(b_end_x)   - DIFF_W'(b_start_x);
    assign dyb_next  = DIFF_W'(b_end_y)   - DIFF_W'(b_start_y);
    assign dx13_next = DIFF_W'(a_start_x) - DIFF_W'(b_start_x);
    assign dy13_next = DIFF_W'(a_start_y) - DIFF_W'(b_start_y);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dxa_s1_reg <= dxa_next;
            dya_s1_reg <= dya_next;
            dxb_reg    <= dxb_next;
            dyb_reg    <= dyb_next;
            dx13_reg   <= dx13_next;
            dy13_reg   <= dy13_next;
            x1_s1_reg  <= a_start_x;
            y1_s1_reg  <= a_start_y;
        end
    end

    // stage 2: the six cross products
    logic signed [PROD_W-1:0] pd0_next, pd1_next, pa0_next, pa1_next, pb0_next, pb1_next;
    logic signed [PROD_W-1:0] pd0_reg, pd1_reg, pa0_reg, pa1_reg, pb0_reg, pb1_reg;
    logic signed [DIFF_W-1:0] dxa_s2_reg, dya_s2_reg;
    coord_t                   x1_s2_reg, y1_s2_reg;

    assign pd0_next = PROD_W'(dyb_reg) * PROD_W'(dxa_s1_reg);
    assign pd1_next = PROD_W'(dxb_reg) * PROD_W'(dya_s1_reg);
    assign pa0_next = PROD_W'(dxb_reg) * PROD_W'(dy13_reg);
    assign pa1_next = PROD_W'(dyb_reg) * PROD_W'(dx13_reg);
    assign pb0_next = PROD_W'(dxa_s1_reg) * PROD_W'(dy13_reg);
    assign pb1_next = PROD_W'(dya_s1_reg) * PROD_W'(dx13_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pd0_reg    <= pd0_next;
            pd1_reg    <= pd1_next;
            pa0_reg    <= pa0_next;
            pa1_reg    <= pa1_next;
            pb0_reg    <= pb0_next;
            pb1_reg    <= pb1_next;
            dxa_s2_reg <= dxa_s1_reg;
            dya_s2_reg <= dya_s1_reg;
            x1_s2_reg  <= x1_s1_reg;
            y1_s2_reg  <= y1_s1_reg;
        end
    end

    // stage 3: denominator and both parameter numerators
    logic signed [DEN_W-1:0]  den_next, numa_next, numb_next;
    logic signed [DEN_W-1:0]  den_s3_reg, numa_reg, numb_reg;
    logic signed [DIFF_W-1:0] dxa_s3_reg, dya_s3_reg;
    coord_t                   x1_s3_reg, y1_s3_reg;

    assign den_next  = DEN_W'(pd0_reg) - DEN_W'(pd1_reg);
    assign numa_next = DEN_W'(pa0_reg) - DEN_W'(pa1_reg);
    assign numb_next = DEN_W'(pb0_reg) - DEN_W'(pb1_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            den_s3_reg <= den_next;
            numa_reg   <= numa_next;
            numb_reg   <= numb_next;
            dxa_s3_reg <= dxa_s2_reg;
            dya_s3_reg <= dya_s2_reg;
            x1_s3_reg  <= x1_s2_reg;
            y1_s3_reg  <= y1_s2_reg;
        end
    end

    // stage 4: hit test and the point products
    logic                    hit_next;
    logic                    hit_s4_reg;
    logic signed [NUM_W-1:0] mxd_next, mxn_next, myd_next, myn_next;
    logic signed [NUM_W-1:0] mxd_reg, mxn_reg, myd_reg, myn_reg;
    logic signed [DEN_W-1:0] den_s4_reg;

    assign hit_next = (den_s3_reg != '0) && in_unit(numa_reg, den_s3_reg)
                      && in_unit(numb_reg, den_s3_reg);
    assign mxd_next = NUM_W'(x1_s3_reg) * NUM_W'(den_s3_reg);
    assign mxn_next = NUM_W'(numa_reg)  * NUM_W'(dxa_s3_reg);
    assign myd_next = NUM_W'(y1_s3_reg) * NUM_W'(den_s3_reg);
    assign myn_next = NUM_W'(numa_reg)  * NUM_W'(dya_s3_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hit_s4_reg <= hit_next;
            mxd_reg    <= mxd_next;
            mxn_reg    <= mxn_next;
            myd_reg    <= myd_next;
            myn_reg    <= myn_next;
            den_s4_reg <= den_s3_reg;
        end
    end

    // stage 5: point numerators
    logic signed [NUM_W-1:0] sum_x_next, sum_y_next;
    logic signed [NUM_W-1:0] sum_x_reg, sum_y_reg;
    logic signed [DEN_W-1:0] den_s5_reg;
    logic                    hit_s5_reg;

    assign sum_x_next = mxd_reg + mxn_reg;
    assign sum_y_next = myd_reg + myn_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sum_x_reg  <= sum_x_next;
            sum_y_reg  <= sum_y_next;
            den_s5_reg <= den_s4_reg;
            hit_s5_reg <= hit_s4_reg;
        end
    end

    // stage 6: magnitudes and quotient signs for the divider
    segi_div_req_t req_next;
    segi_div_req_t req_reg;

    always_comb
    begin
        req_next.hit   = hit_s5_reg;
        req_next.neg_x = sum_x_reg[NUM_W-1] ^ den_s5_reg[DEN_W-1];
        req_next.neg_y = sum_y_reg[NUM_W-1] ^ den_s5_reg[DEN_W-1];
        req_next.mag_x = sum_x_reg[NUM_W-1] ? -sum_x_reg : sum_x_reg;
        req_next.mag_y = sum_y_reg[NUM_W-1] ? -sum_y_reg : sum_y_reg;
        req_next.mag_d = den_s5_reg[DEN_W-1] ? -den_s5_reg : den_s5_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            req_reg <= req_next;
        end
    end

    assign req = req_reg;

endmodule

>>> rtl/segi_div.sv
// segi_div: pipelined restoring divider, one quotient bit per stage, x and y side by side
// depends on segi_pkg
module segi_div import segi_pkg::*; (
    input  logic          clk,
    input  logic          en,
    input  segi_div_req_t req,
    output segi_div_rsp_t rsp
);

    // one restoring step: shift in the next dividend bit, subtract when it fits
    function automatic logic [DEN_W+QUO_W-1:0] div_step(input logic [DEN_W-1:0] rem,
                                                        input logic [QUO_W-1:0] sh,
                                                        input logic [DEN_W-1:0] d);
        logic [DEN_W:0]   trial;
        logic [DEN_W:0]   diff;
        logic [DEN_W-1:0] rem_out;
        logic             qbit;
        trial = {rem, sh[QUO_W-1]};
        diff  = trial - {1'b0, d};
        qbit  = (trial >= {1'b0, d});
        rem_out = qbit ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        return {rem_out, sh[QUO_W-2:0], qbit};
    endfunction

    logic [DEN_W-1:0] rem_x_reg [DIV_STAGES];
    logic [DEN_W-1:0] rem_y_reg [DIV_STAGES];
    logic [QUO_W-1:0] sh_x_reg  [DIV_STAGES];
    logic [QUO_W-1:0] sh_y_reg  [DIV_STAGES];
    logic [DEN_W-1:0] d_reg     [DIV_STAGES];
    logic             hit_reg   [DIV_STAGES];
    logic             neg_x_reg [DIV_STAGES];
    logic             neg_y_reg [DIV_STAGES];

    for (genvar k = 0; k < DIV_STAGES; k++)
    begin : g_stage
        logic [DEN_W-1:0] rem_x_in, rem_y_in, d_in;
        logic [QUO_W-1:0] sh_x_in, sh_y_in;
        logic             hit_in, neg_x_in, neg_y_in;
        logic [DEN_W+QUO_W-1:0] step_x_next, step_y_next;

        if (k == 0)
        begin : g_first
            // the dividend bits above the quotient width seed the remainder
            assign rem_x_in = DEN_W'(req.mag_x >> QUO_W);
            assign rem_y_in = DEN_W'(req.mag_y >> QUO_W);
            assign sh_x_in  = req.mag_x[QUO_W-1:0];
            assign sh_y_in  = req.mag_y[QUO_W-1:0];
            assign d_in     = req.mag_d;
            assign hit_in   = req.hit;
            assign neg_x_in = req.neg_x;
            assign neg_y_in = req.neg_y;
        end
        else
        begin : g_next
            assign rem_x_in = rem_x_reg[k-1];
            assign rem_y_in = rem_y_reg[k-1];
            assign sh_x_in  = sh_x_reg[k-1];
            assign sh_y_in  = sh_y_reg[k-1];
            assign d_in     = d_reg[k-1];
            assign hit_in   = hit_reg[k-1];
            assign neg_x_in = neg_x_reg[k-1];
            assign neg_y_in = neg_y_reg[k-1];
        end

        assign step_x_next = div_step(rem_x_in, sh_x_in, d_in);
        assign step_y_next = div_step(rem_y_in, sh_y_in, d_in);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                {rem_x_reg[k], sh_x_reg[k]} <= step_x_next;
                {rem_y_reg[k], sh_y_reg[k]} <= step_y_next;
                d_reg[k]     <= d_in;
                hit_reg[k]   <= hit_in;
                neg_x_reg[k] <= neg_x_in;
                neg_y_reg[k] <= neg_y_in;
            end
        end
    end

    assign rsp.hit   = hit_reg[DIV_STAGES-1];
    assign rsp.neg_x = neg_x_reg[DIV_STAGES-1];
    assign rsp.neg_y = neg_y_reg[DIV_STAGES-1];
    assign rsp.quo_x = sh_x_reg[DIV_STAGES-1];
    assign rsp.quo_y = sh_y_reg[DIV_STAGES-1];

endmodule

>>> rtl/segment_intersection_top.sv
// segment_intersection_top: pipeline control, output skid buffer and checks
// depends on segi_pkg, segi_in_if, segi_out_if, segi_front, segi_div
//
// Takes one pair of segments per clock while the output buffer has room and returns one result
// per item, in order: a hit flag and, on a hit, the crossing point truncated toward zero (zero
// otherwise). Parallel and collinear pairs never hit; touching at an end point does. Each item
// passes six front-end stages (differences, cross products, range test, point numerators,
// magnitudes), then a restoring divider that settles one quotient bit per stage, then the output
// register. The whole pipeline moves together and halts only when the two-entry output buffer
// is full, so a stalled output costs nothing while the buffer still has room.
module segment_intersection_top import segi_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    segi_in_if.sink     seg_in,
    segi_out_if.source  seg_out
);

    logic                   advance;
    logic [PIPE_STAGES-1:0] valid_reg, valid_next;
    logic [SKID_CNT_W-1:0]  skid_cnt_reg, skid_cnt_next;
    segi_div_req_t          div_req;
    segi_div_rsp_t          div_rsp;

    // pipeline holds only while the output buffer is full
    assign advance      = (skid_cnt_reg != SKID_CNT_W'(SKID_DEPTH));
    assign seg_in.ready = advance;

    assign valid_next = {valid_reg[PIPE_STAGES-2:0], seg_in.valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (advance)
        begin
            valid_reg <= valid_next;
        end
    end

    segi_front u_front (
        .clk       (clk),
        .en        (advance),
        .a_start_x (seg_in.a_start_x),
        .a_start_y (seg_in.a_start_y),
        .a_end_x   (seg_in.a_end_x),
        .a_end_y   (seg_in.a_end_y),
        .b_start_x (seg_in.b_start_x),
        .b_start_y (seg_in.b_start_y),
        .b_end_x   (seg_in.b_end_x),
        .b_end_y   (seg_in.b_end_y),
        .req       (div_req)
    );

    segi_div u_div (
        .clk (clk),
        .en  (advance),
        .req (div_req),
        .rsp (div_rsp)
    );

    // sign and hit correction of the quotients
    coord_t q_x, q_y;
    coord_t cross_x_next, cross_y_next;

    assign q_x = $signed(div_rsp.quo_x[COORD_W-1:0]);
    assign q_y = $signed(div_rsp.quo_y[COORD_W-1:0]);

    always_comb
    begin
        cross_x_next = '0;
        cross_y_next = '0;
        if (div_rsp.hit)
        begin
            cross_x_next = div_rsp.neg_x ? -q_x : q_x;
            cross_y_next = div_rsp.neg_y ? -q_y : q_y;
        end
    end

    // two-entry output buffer: head drives the port, spare catches the item in flight
    logic                  push, pop;
    logic                  head_hit_reg, spare_hit_reg;
    coord_t                head_x_reg, head_y_reg, spare_x_reg, spare_y_reg;

    assign push = advance && valid_reg[PIPE_STAGES-1];
    assign pop  = seg_out.valid && seg_out.ready;

    always_comb
    begin
        skid_cnt_next = skid_cnt_reg;
        if (push && !pop)
        begin
            skid_cnt_next = skid_cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            skid_cnt_next = skid_cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            skid_cnt_reg <= '0;
        end
        else
        begin
            skid_cnt_reg <= skid_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop && (skid_cnt_reg == SKID_CNT_W'(SKID_DEPTH)))
        begin
            head_hit_reg <= spare_hit_reg;
            head_x_reg   <= spare_x_reg;
            head_y_reg   <= spare_y_reg;
        end
        else if (push && ((skid_cnt_reg == '0) || pop))
        begin
            head_hit_reg <= div_rsp.hit;
            head_x_reg   <= cross_x_next;
            head_y_reg   <= cross_y_next;
        end

        if (push && (((skid_cnt_reg == SKID_CNT_W'(1)) && !pop)
                     || (skid_cnt_reg == SKID_CNT_W'(SKID_DEPTH))))
        begin
            spare_hit_reg <= div_rsp.hit;
            spare_x_reg   <= cross_x_next;
            spare_y_reg   <= cross_y_next;
        end
    end

    assign seg_out.valid   = (skid_cnt_reg != '0);
    assign seg_out.hit     = head_hit_reg;
    assign seg_out.cross_x = head_x_reg;
    assign seg_out.cross_y = head_y_reg;

    // a miss always reports the origin
    assert property (@(posedge clk) disable iff (!rst_n)
        seg_out.valid && !seg_out.hit |-> (seg_out.cross_x == '0) && (seg_out.cross_y == '0))
        else $error("miss with nonzero point");

    // an accepted item occupies the first stage next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        seg_in.valid && seg_in.ready |=> valid_reg[0])
        else $error("accepted item lost at pipeline entry");

    // a held pipeline keeps every item in place
    assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(valid_reg))
        else $error("pipeline moved while held");

    // a full buffer with a stalled output stays full
    assert property (@(posedge clk) disable iff (!rst_n)
        (skid_cnt_reg == SKID_CNT_W'(SKID_DEPTH)) && !seg_out.ready
        |=> (skid_cnt_reg == SKID_CNT_W'(SKID_DEPTH)))
        else $error("output buffer dropped an item");

endmodule

>>> test/tb_segment_intersection_top.sv
// testbench for segment_intersection_top: directed and random segment pairs, in-order result check
// depends on segi_pkg, segi_in_if, segi_out_if and the segment_intersection_top rtl
`timescale 1ns / 1ps

module tb_segment_intersection_top;
    import segi_pkg::*;

    localparam int QUIET_LIMIT = 4000;
    localparam int DRAIN_CYCLES = PIPE_STAGES + 8;

    typedef struct packed {
        coord_t a_start_x;
        coord_t a_start_y;
        coord_t a_end_x;
        coord_t a_end_y;
        coord_t b_start_x;
        coord_t b_start_y;
        coord_t b_end_x;
        coord_t b_end_y;
    } segment_pair_t;

    typedef struct packed {
        logic   hit;
        coord_t cross_x;
        coord_t cross_y;
    } crossing_t;

    logic clk;
    logic rst_n;

    segi_in_if  seg_in();
    segi_out_if seg_out();

    segment_intersection_top u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .seg_in  (seg_in),
        .seg_out (seg_out)
    );

    crossing_t crossing_q[$];
    int        error_count = 0;
    int        quiet_cycles = 0;
    bit        source_idle_on = 1'b1;
    bit        sink_idle_on = 1'b1;
    int        sink_hold_cycles = 0;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // ---------------------------------------------------------------- prediction

    function automatic logic unit_ratio(input longint num, input longint den);
        if (den > 0)
            return (num >= 0) && (num <= den);
        return (num <= 0) && (num >= den);
    endfunction

    // 64-bit signed quotient truncated toward zero, via magnitudes
    function automatic longint trunc_div(input longint num, input longint den);
        logic [63:0] mag_n;
        logic [63:0] mag_d;
        logic [63:0] quo;
        mag_n = (num < 0) ? 64'(-num) : 64'(num);
        mag_d = (den < 0) ? 64'(-den) : 64'(den);
        if (mag_d == 0)
            return 0;
        quo = mag_n / mag_d;
        return ((num < 0) != (den < 0)) ? -longint'(quo) : longint'(quo);
    endfunction

    function automatic crossing_t predict_crossing(input segment_pair_t p);
        longint    x1, y1, x2, y2, x3, y3, x4, y4;
        longint    dxa, dya, dxb, dyb, dx13, dy13;
        longint    den, num_a, num_b;
        crossing_t r;
        x1 = longint'(p.a_start_x);
        y1 = longint'(p.a_start_y);
        x2 = longint'(p.a_end_x);
        y2 = longint'(p.a_end_y);
        x3 = longint'(p.b_start_x);
        y3 = longint'(p.b_start_y);
        x4 = longint'(p.b_end_x);
        y4 = longint'(p.b_end_y);
        dxa  = x2 - x1;
        dya  = y2 - y1;
        dxb  = x4 - x3;
        dyb  = y4 - y3;
        dx13 = x1 - x3;
        dy13 = y1 - y3;
        den   = dyb * dxa - dxb * dya;
        num_a = dxb * dy13 - dyb * dx13;
        num_b = dxa * dy13 - dya * dx13;
        r = '0;
        if (den == 0)
            return r;
        if (!unit_ratio(num_a, den) || !unit_ratio(num_b, den))
            return r;
        r.hit     = 1'b1;
        r.cross_x = coord_t'(trunc_div(x1 * den + num_a * dxa, den));
        r.cross_y = coord_t'(trunc_div(y1 * den + num_a * dya, den));
        return r;
    endfunction

    // ---------------------------------------------------------------- stimulus helpers

    function automatic int rand_between(input int lo, input int hi);
        return lo + int'($urandom_range(0, hi - lo));
    endfunction

    function automatic segment_pair_t make_pair(input int ax1, input int ay1, input int ax2,
                                                input int ay2, input int bx1, input int by1,
                                                input int bx2, input int by2);
        segment_pair_t p;
        p.a_start_x = coord_t'(ax1);
        p.a_start_y = coord_t'(ay1);
        p.a_end_x   = coord_t'(ax2);
        p.a_end_y   = coord_t'(ay2);
        p.b_start_x = coord_t'(bx1);
        p.b_start_y = coord_t'(by1);
        p.b_end_x   = coord_t'(bx2);
        p.b_end_y   = coord_t'(by2);
        return p;
    endfunction

    function automatic int extreme_coord();
        case ($urandom_range(0, 7))
            0: return -32768;
            1: return -32767;
            2: return -1;
            3: return 0;
            4: return 1;
            5: return 32766;
            6: return 32767;
            default: return rand_between(-32768, 32767);
        endcase
    endfunction

    // pair of segments that both pass through a common lattice point
    function automatic segment_pair_t crossing_pair();
        int cx, cy, ux, uy, vx, vy, ka1, ka2, kb1, kb2;
        cx = rand_between(-16000, 16000);
        cy = rand_between(-16000, 16000);
        ux = rand_between(-127, 127);
        uy = rand_between(-127, 127);
        vx = rand_between(-127, 127);
        vy = rand_between(-127, 127);
        ka1 = ($urandom_range(0, 7) == 0) ? 0 : rand_between(0, 127);
        ka2 = rand_between(0, 127);
        kb1 = rand_between(0, 127);
        kb2 = ($urandom_range(0, 7) == 0) ? 0 : rand_between(0, 127);
        return make_pair(cx - ka1 * ux, cy - ka1 * uy, cx + ka2 * ux, cy + ka2 * uy,
                         cx - kb1 * vx, cy - kb1 * vy, cx + kb2 * vx, cy + kb2 * vy);
    endfunction

    // parallel pairs, collinear ones among them
    function automatic segment_pair_t parallel_pair();
        int sx, sy, dx, dy, ox, oy, ka, kb, j;
        sx = rand_between(-16000, 16000);
        sy = rand_between(-16000, 16000);
        dx = rand_between(-63, 63);
        dy = rand_between(-63, 63);
        ka = rand_between(-63, 63);
        kb = rand_between(-63, 63);
        if ($urandom_range(0, 1) == 0)
        begin
            j  = rand_between(-63, 63);
            ox = j * dx;
            oy = j * dy;
        end
        else
        begin
            ox = rand_between(-8000, 8000);
            oy = rand_between(-8000, 8000);
        end
        return make_pair(sx, sy, sx + ka * dx, sy + ka * dy,
                         sx + ox, sy + oy, sx + ox + kb * dx, sy + oy + kb * dy);
    endfunction

    function automatic segment_pair_t random_pair();
        int sel, cx, cy;
        sel = $urandom_range(0, 99);
        if (sel < 35)
            return crossing_pair();
        if (sel < 65)
            return segment_pair_t'({$urandom, $urandom, $urandom, $urandom});
        if (sel < 80)
        begin
            cx = rand_between(-32000, 32000);
            cy = rand_between(-32000, 32000);
            return make_pair(cx + rand_between(-64, 64), cy + rand_between(-64, 64),
                             cx + rand_between(-64, 64), cy + rand_between(-64, 64),
                             cx + rand_between(-64, 64), cy + rand_between(-64, 64),
                             cx + rand_between(-64, 64), cy + rand_between(-64, 64));
        end
        if (sel < 90)
            return parallel_pair();
        return make_pair(extreme_coord(), extreme_coord(), extreme_coord(), extreme_coord(),
                         extreme_coord(), extreme_coord(), extreme_coord(), extreme_coord());
    endfunction

    // ---------------------------------------------------------------- source side

    task automatic send_pair(input segment_pair_t p);
        if (source_idle_on && $urandom_range(0, 4) == 0)
        begin
            seg_in.valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
        seg_in.valid     <= 1'b1;
        seg_in.a_start_x <= p.a_start_x;
        seg_in.a_start_y <= p.a_start_y;
        seg_in.a_end_x   <= p.a_end_x;
        seg_in.a_end_y   <= p.a_end_y;
        seg_in.b_start_x <= p.b_start_x;
        seg_in.b_start_y <= p.b_start_y;
        seg_in.b_end_x   <= p.b_end_x;
        seg_in.b_end_y   <= p.b_end_y;
        do
            @(posedge clk);
        while (!(seg_in.valid && seg_in.ready));
        crossing_q.push_back(predict_crossing(p));
    endtask

    task automatic wait_until_drained();
        seg_in.valid <= 1'b0;
        while (crossing_q.size() != 0)
            @(posedge clk);
    endtask

    // ---------------------------------------------------------------- sink side

    always @(posedge clk)
    begin
        crossing_t want;
        if (rst_n && seg_out.valid && seg_out.ready)
        begin
            if (crossing_q.size() == 0)
            begin
                $display("%0t: unexpected item: hit=%0b x=%0d y=%0d", $time,
                         seg_out.hit, seg_out.cross_x, seg_out.cross_y);
                error_count++;
            end
            else
            begin
                want = crossing_q.pop_front();
                if (seg_out.hit !== want.hit)
                begin
                    $display("%0t: hit mismatch: expected %0b actual %0b", $time,
                             want.hit, seg_out.hit);
                    error_count++;
                end
                if (seg_out.cross_x !== want.cross_x)
                begin
                    $display("%0t: cross_x mismatch: expected %0d actual %0d", $time,
                             want.cross_x, seg_out.cross_x);
                    error_count++;
                end
                if (seg_out.cross_y !== want.cross_y)
                begin
                    $display("%0t: cross_y mismatch: expected %0d actual %0d", $time,
                             want.cross_y, seg_out.cross_y);
                    error_count++;
                end
            end
        end
    end

    // one ready update per loop pass, then time moves on
    initial
    begin
        forever
        begin
            if (sink_hold_cycles > 0)
            begin
                seg_out.ready <= 1'b0;
                repeat (sink_hold_cycles) @(posedge clk);
                sink_hold_cycles = 0;
            end
            else if (sink_idle_on && $urandom_range(0, 3) == 0)
            begin
                seg_out.ready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge clk);
            end
            else
            begin
                seg_out.ready <= 1'b1;
                repeat ($urandom_range(1, 19)) @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (seg_in.valid && seg_in.ready) || (seg_out.valid && seg_out.ready))
            quiet_cycles <= 0;
        else if (quiet_cycles + 1 >= QUIET_LIMIT)
        begin
            $display("%0t: no item moved for %0d cycles", $time, QUIET_LIMIT);
            $display("tb_segment_intersection_top failed");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // ---------------------------------------------------------------- tests

    task automatic test_directed();
        // basic x crossing and its mirror with the other denominator sign
        send_pair(make_pair(0, 0, 10, 10, 0, 10, 10, 0));
        send_pair(make_pair(0, 0, 10, 10, 10, 0, 0, 10));
        // non-integer points with negative coordinates, truncation toward zero
        send_pair(make_pair(-7, -3, 2, 4, -6, 3, 1, -5));
        send_pair(make_pair(-1, 0, -4, 3, -4, 0, -1, 2));
        // parallel and collinear overlapping
        send_pair(make_pair(0, 0, 10, 0, 0, 5, 10, 5));
        send_pair(make_pair(0, 0, 10, 10, 5, 5, 15, 15));
        // end of a touches start of b, and start of a touches b's interior
        send_pair(make_pair(0, 0, 10, 0, 10, 0, 10, 10));
        send_pair(make_pair(0, 0, 10, 0, 0, -5, 0, 5));
        // lines cross outside one extent
        send_pair(make_pair(0, 0, 1, 1, 10, 0, 0, 10));
        send_pair(make_pair(0, 0, 10, 10, 20, 0, 12, 8));
        // degenerate point segment
        send_pair(make_pair(3, 3, 3, 3, 0, 0, 6, 6));
        // full-range extremes
        send_pair(make_pair(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768));
        send_pair(make_pair(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767));
        send_pair(make_pair(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768));
        send_pair(make_pair(-32768, 32767, 32767, -32768, 32767, 32767, -32768, -32768));
        send_pair(make_pair(-32768, 0, 32767, 0, 0, -32768, 0, 32767));
        send_pair(make_pair(32767, -32768, -32768, 32767, -32768, -32767, 32767, 32766));
        send_pair(make_pair(-32768, -32768, 32767, -32767, 32767, -32768, -32768, -32767));
    endtask

    task automatic test_random_mix(input int count);
        repeat (count) send_pair(random_pair());
    endtask

    task automatic test_output_hold();
        // receiver stops long enough for the pipeline and output buffer to fill
        source_idle_on   = 1'b0;
        sink_hold_cycles = 300;
        repeat (80) send_pair(random_pair());
        source_idle_on = 1'b1;
    endtask

    task automatic test_source_pause();
        repeat (30) send_pair(random_pair());
        wait_until_drained();
        repeat (30) send_pair(crossing_pair());
        wait_until_drained();
        repeat (30) send_pair(random_pair());
    endtask

    task automatic test_full_rate(input int count);
        source_idle_on = 1'b0;
        sink_idle_on   = 1'b0;
        repeat (count) send_pair(random_pair());
    endtask

    initial
    begin
        rst_n            = 1'b0;
        seg_in.valid     <= 1'b0;
        seg_in.a_start_x <= '0;
        seg_in.a_start_y <= '0;
        seg_in.a_end_x   <= '0;
        seg_in.a_end_y   <= '0;
        seg_in.b_start_x <= '0;
        seg_in.b_start_y <= '0;
        seg_in.b_end_x   <= '0;
        seg_in.b_end_y   <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random_mix(860);
        test_output_hold();
        test_source_pause();
        test_full_rate(200);

        wait_until_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("tb_segment_intersection_top passed");
        else
            $display("tb_segment_intersection_top failed");
        $finish;
    end

endmodule
